@@ rtl/cwadc_pkg.sv @@
package cwadc_pkg;

  localparam logic [2:0] MODE_DISPLAY    = 3'd0;
  localparam logic [2:0] MODE_TIME_SET   = 3'd1;
  localparam logic [2:0] MODE_ALARM_SET  = 3'd2;
  localparam logic [2:0] MODE_SNOOZE     = 3'd3;
  localparam logic [2:0] MODE_CORRECTION = 3'd4;

  localparam logic [3:0] CODE_BLANK    = 4'd10;
  localparam logic [3:0] CODE_LETTER_C = 4'd11;
  localparam logic [3:0] CODE_MINUS    = 4'd12;

  localparam logic [7:0] SEC_PER_MIN   = 8'd60;
  localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
  localparam logic [5:0] MIN_LAST      = 6'd59;
  localparam logic [4:0] HOUR_PER_DAY  = 5'd24;
  localparam logic [4:0] HOUR_LAST     = 5'd23;
  localparam logic [2:0] DAY_PER_WEEK  = 3'd7;

  localparam logic signed [7:0] CORR_MAX = 8'sd99;
  localparam logic signed [7:0] CORR_MIN = -8'sd99;

  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic       action;
    logic [2:0] mode;
    logic       press_minutes;
    logic       press_hours;
    logic       reset_seconds;
    logic       alarm_enable;
  } item_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [7:0] seconds;
    logic       ringing;
    logic       alarm_en;
    logic [2:0] view;
    logic [4:0] alarm_hours;
    logic [5:0] alarm_minutes;
    logic [7:0] corr;
  } clk_state_t;

  typedef struct packed {
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
    logic [3:0] d3;
  } digits_t;

  // quotient by 7 for values up to 128
  function automatic logic [7:0] div7(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd147;
    return p[15:10] == 6'd0 ? 8'd0 : {2'd0, p[15:10]};
  endfunction

  // quotient by 10 for values up to 255
  function automatic logic [7:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd205;
    return {3'd0, p[15:11]};
  endfunction

endpackage

@@ rtl/clock_with_alarm_and_drift_correction.sv @@
// channel | dir | tdata (low bit up)                              | tuser
// in_     | in  | mode[2:0] press_minutes press_hours             | action
//         |     | reset_seconds alarm_enable, pad to 8            |
// out_    | out | hours minutes seconds alarm_ringing speaker_gate| -
//         |     | digit_zero..digit_three colon display_update    |
// One item per cycle sustained while the output is not stalled.
// Input register, then state update and digit encoding, then output register.
// Synchronous active-low reset clears the clock, alarm and correction state.
// A stalled output holds the input register; in_tready drops only when both are full.
module clock_with_alarm_and_drift_correction
  import cwadc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // mode, press_minutes, press_hours,
                                            // reset_seconds, alarm_enable, zeros
  input  logic                  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // hours, minutes, seconds, alarm_ringing,
                                            // speaker_gate, digit_zero, digit_one,
                                            // digit_two, digit_three, colon,
                                            // display_update, zero
);

  item_t                 item_r;
  logic                  in_valid_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  advance, step;
  clk_state_t            st_nxt;
  digits_t               dig;
  logic                  odd;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign step      = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{action: in_tuser, mode: in_tdata[2:0], press_minutes: in_tdata[3],
                  press_hours: in_tdata[4], reset_seconds: in_tdata[5],
                  alarm_enable: in_tdata[6]};
    end
  end

  cwadc_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .st_nxt (st_nxt)
  );

  cwadc_digits u_digits (
    .st  (st_nxt),
    .dig (dig)
  );

  assign odd = st_nxt.seconds[0];

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {1'b0,
                     !(st_nxt.ringing && odd),
                     odd && (st_nxt.view != MODE_CORRECTION),
                     dig.d3, dig.d2, dig.d1, dig.d0,
                     st_nxt.ringing && st_nxt.alarm_en && odd,
                     st_nxt.ringing,
                     st_nxt.seconds, st_nxt.minutes, st_nxt.hours};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_out_hours: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] < HOUR_PER_DAY)
    else $error("hour field out of range");
  a_speaker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> out_tdata[19] && out_tdata[11] && !out_tdata[38])
    else $error("speaker on without ringing odd second");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(item_r))
    else $error("input register lost item under stall");

endmodule

@@ rtl/cwadc_state.sv @@
module cwadc_state
  import cwadc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  item_t      item,
  output clk_state_t st_nxt
);

  logic [7:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [2:0] wday_r, wday_nxt;
  logic [4:0] ahour_r, ahour_nxt;
  logic [5:0] amin_r, amin_nxt;
  logic [7:0] corr_r, corr_nxt;
  logic       ring_r, ring_nxt;
  logic       aen_r, aen_nxt;
  logic [2:0] view_r, view_nxt;

  logic [7:0] sec_inc;
  logic [5:0] min_inc;
  logic [4:0] hour_inc;
  logic [2:0] wday_inc;
  logic [7:0] corr_mag, quo, rem, quo_s, rem_s;
  logic       corr_neg;
  logic [2:0] mode_eff;
  logic signed [7:0] corr_s, corr_up, corr_dn;

  assign sec_inc  = sec_r + 8'd1;
  assign min_inc  = min_r + 6'd1;
  assign hour_inc = hour_r + 5'd1;
  assign wday_inc = wday_r + 3'd1;

  assign corr_neg = corr_r[7];
  assign corr_mag = corr_neg ? (8'd0 - corr_r) : corr_r;
  assign quo      = div7(corr_mag);
  assign rem      = corr_mag - ((quo << 3) - quo);
  assign quo_s    = corr_neg ? (8'd0 - quo) : quo;
  assign rem_s    = corr_neg ? (8'd0 - rem) : rem;

  assign corr_s  = signed'(corr_r);
  assign corr_up = (item.press_minutes && (corr_s < CORR_MAX)) ? corr_s + 8'sd1 : corr_s;
  assign corr_dn = (item.press_hours && (corr_up > CORR_MIN)) ? corr_up - 8'sd1 : corr_up;

  assign mode_eff = (item.mode > MODE_CORRECTION) ? MODE_DISPLAY : item.mode;

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    wday_nxt  = wday_r;
    ahour_nxt = ahour_r;
    amin_nxt  = amin_r;
    corr_nxt  = corr_r;
    ring_nxt  = ring_r;
    aen_nxt   = aen_r;
    view_nxt  = view_r;
    if (!item.action) begin
      sec_nxt = sec_inc;
      if (sec_inc == SEC_PER_MIN) begin
        sec_nxt = 8'd0;
        min_nxt = min_inc;
        if (min_inc == MIN_PER_HOUR) begin
          min_nxt  = 6'd0;
          hour_nxt = hour_inc;
          if (hour_inc == HOUR_PER_DAY) begin
            hour_nxt = 5'd0;
            wday_nxt = wday_inc;
            sec_nxt  = quo_s;
            if (wday_inc == DAY_PER_WEEK) begin
              wday_nxt = 3'd0;
              sec_nxt  = quo_s + rem_s;
            end
          end
        end
        ring_nxt = (hour_nxt == ahour_r) && (min_nxt == amin_r);
      end
    end else begin
      aen_nxt  = item.alarm_enable;
      view_nxt = mode_eff;
      unique case (mode_eff)
        MODE_TIME_SET: begin
          if (item.press_minutes) min_nxt = (min_r == MIN_LAST) ? 6'd0 : min_inc;
          if (item.press_hours) hour_nxt = (hour_r == HOUR_LAST) ? 5'd0 : hour_inc;
        end
        MODE_ALARM_SET: begin
          if (item.press_minutes) amin_nxt = (amin_r == MIN_LAST) ? 6'd0 : amin_r + 6'd1;
          if (item.press_hours) ahour_nxt = (ahour_r == HOUR_LAST) ? 5'd0 : ahour_r + 5'd1;
        end
        MODE_SNOOZE: begin
          ring_nxt = 1'b0;
        end
        MODE_CORRECTION: begin
          corr_nxt = unsigned'(corr_dn);
        end
        default: begin
          if (item.reset_seconds) sec_nxt = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= '0;
      wday_r  <= '0;
      ahour_r <= '0;
      amin_r  <= '0;
      corr_r  <= '0;
      ring_r  <= 1'b0;
      aen_r   <= 1'b0;
      view_r  <= MODE_DISPLAY;
    end else if (step) begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      wday_r  <= wday_nxt;
      ahour_r <= ahour_nxt;
      amin_r  <= amin_nxt;
      corr_r  <= corr_nxt;
      ring_r  <= ring_nxt;
      aen_r   <= aen_nxt;
      view_r  <= view_nxt;
    end
  end

  assign st_nxt.hours         = hour_nxt;
  assign st_nxt.minutes       = min_nxt;
  assign st_nxt.seconds       = sec_nxt;
  assign st_nxt.ringing       = ring_nxt;
  assign st_nxt.alarm_en      = aen_nxt;
  assign st_nxt.view          = view_nxt;
  assign st_nxt.alarm_hours   = ahour_nxt;
  assign st_nxt.alarm_minutes = amin_nxt;
  assign st_nxt.corr          = corr_nxt;

  a_min_range: assert property (@(posedge clk) disable iff (!rst_n) min_r < MIN_PER_HOUR)
    else $error("minute count out of range");
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n) hour_r < HOUR_PER_DAY)
    else $error("hour count out of range");
  a_wday_range: assert property (@(posedge clk) disable iff (!rst_n) wday_r < DAY_PER_WEEK)
    else $error("week day out of range");
  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (corr_s <= CORR_MAX) && (corr_s >= CORR_MIN))
    else $error("correction beyond limits");
  a_ring_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.action && (item.mode == MODE_SNOOZE) |=> !ring_r)
    else $error("snooze left ringing set");

endmodule

@@ rtl/cwadc_digits.sv @@
module cwadc_digits
  import cwadc_pkg::*;
(
  input  clk_state_t st,
  output digits_t    dig
);

  logic [7:0] corr_mag, corr_tens, hv, mv, h_tens, m_tens;

  assign corr_mag  = st.corr[7] ? (8'd0 - st.corr) : st.corr;
  assign corr_tens = div10(corr_mag);
  assign hv        = (st.view == MODE_ALARM_SET) ? {3'd0, st.alarm_hours} : {3'd0, st.hours};
  assign mv        = (st.view == MODE_ALARM_SET) ? {2'd0, st.alarm_minutes}
                                                 : {2'd0, st.minutes};
  assign h_tens    = div10(hv);
  assign m_tens    = div10(mv);

  always_comb begin
    if (st.view == MODE_CORRECTION) begin
      dig.d0 = CODE_LETTER_C;
      dig.d1 = st.corr[7] ? CODE_MINUS : CODE_BLANK;
      dig.d2 = corr_tens[3:0];
      dig.d3 = 4'(corr_mag - (corr_tens << 3) - (corr_tens << 1));
    end else begin
      dig.d0 = (h_tens == 8'd0) ? CODE_BLANK : h_tens[3:0];
      dig.d1 = 4'(hv - (h_tens << 3) - (h_tens << 1));
      dig.d2 = m_tens[3:0];
      dig.d3 = 4'(mv - (m_tens << 3) - (m_tens << 1));
    end
  end

endmodule
